>>> rtl/core/assert_macros.svh
// Assertion helper macros for the word sort checker RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/cwsc_pkg.sv
// Shared types, constants and the rank lookup for the word sort checker.
// No dependencies; imported by the checker top level and its testbench.
package cwsc_pkg;

  localparam int MAX_WORD_LEN = 32;
  localparam int POS_W        = 6;
  localparam int CODE_W       = 5;
  localparam int RANK_W       = 5;
  localparam int NUM_LETTERS  = 26;
  localparam int TBL_W        = NUM_LETTERS * RANK_W;
  localparam int CFG_W        = 60;
  localparam int CFG_HIGH_W   = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int BUF_AW       = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANK_LOW  = 2'd0,
    REG_RANK_MID  = 2'd1,
    REG_RANK_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_EQUAL  = 2'd0,
    ST_AFTER  = 2'd1,
    ST_BEFORE = 2'd2
  } pair_e;

  typedef struct packed {
    logic [CODE_W-1:0] letter_code;
    logic              word_end;
    logic              list_end;
  } in_beat_t;

  typedef struct packed {
    logic pair_in_order;
    logic list_sorted;
    logic list_done;
    logic word_too_long;
  } out_beat_t;

  // letter in flight between the buffer read and the compare
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              cmp_en;
    logic              word_end;
    logic              list_end;
    logic              overflow;
    logic              shorter;
    logic              had_prev;
  } s1_t;

  // codes above z rank last
  function automatic logic [RANK_W-1:0] rank_of(input logic [TBL_W-1:0] tbl,
                                                input logic [CODE_W-1:0] code);
    logic [RANK_W-1:0] r;
    r = '1;
    if (code < CODE_W'(NUM_LETTERS)) begin
      r = tbl[RANK_W*code +: RANK_W];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/cwsc_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
// Read-first: a read of the address written in the same cycle returns old data.
module cwsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/custom_order_word_sort_checker.sv
// Word sort checker under a programmable letter order: one letter per beat in,
// one verdict beat per word out. Sustains one letter per clock; the limit is
// the single previous-word buffer, which each letter reads and overwrites at
// its own position in the same cycle (read-first RAM). A word-end letter passes
// the buffer read into stage 1, then the rank compare into the output register.
// Letters that end no word keep flowing while a verdict is stalled; a word-end
// letter waits only for the output register. The buffer needs no clearing after
// reset, since only positions written by the previous word are ever compared.
// The user must write rank registers only while idle; the block does not
// enforce it. Depends on cwsc_pkg, cwsc_ram and assert_macros.svh.
`include "assert_macros.svh"

module custom_order_word_sort_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [59:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cwsc_pkg::in_beat_t         in_beat_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cwsc_pkg::out_beat_t        out_beat_o
);
  import cwsc_pkg::*;

  logic [CFG_W-1:0]      rank_low_q, rank_mid_q;
  logic [CFG_HIGH_W-1:0] rank_high_q;
  logic [TBL_W-1:0]      rank_tbl;

  logic [POS_W-1:0] letter_pos_q, prev_len_q, new_pos;
  logic             have_prev_q, overflow_q;
  logic             in_fire, store;
  s1_t              s1_d, s1_q;
  logic             s1_valid_q, s1_fire;
  pair_e            pair_q, pair_new;
  logic             sorted_q, in_order;
  logic [CODE_W-1:0] prev_code;
  logic [RANK_W-1:0] rank_new, rank_prev;
  logic             out_valid_q, out_ready;
  out_beat_t        out_q;

  // rank registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_low_q  <= '0;
      rank_mid_q  <= '0;
      rank_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RANK_LOW:  rank_low_q  <= cfg_wdata_i;
        REG_RANK_MID:  rank_mid_q  <= cfg_wdata_i;
        REG_RANK_HIGH: rank_high_q <= cfg_wdata_i[CFG_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign rank_tbl = {rank_high_q, rank_mid_q, rank_low_q};

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_q.word_end || out_ready);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // stage 0: position bookkeeping, buffer read and overwrite
  always_comb begin
    store   = letter_pos_q < POS_W'(MAX_WORD_LEN);
    new_pos = store ? letter_pos_q + POS_W'(1) : letter_pos_q;
    s1_d.code     = in_beat_i.letter_code;
    s1_d.cmp_en   = have_prev_q && store && (letter_pos_q < prev_len_q);
    s1_d.word_end = in_beat_i.word_end;
    s1_d.list_end = in_beat_i.list_end;
    s1_d.overflow = overflow_q || !store;
    s1_d.shorter  = have_prev_q && (new_pos < prev_len_q);
    s1_d.had_prev = have_prev_q;
  end

  cwsc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_WORD_LEN)
  ) u_prev_word (
    .clk_i   (clk_i),
    .we_i    (in_fire && store),
    .waddr_i (letter_pos_q[BUF_AW-1:0]),
    .wdata_i (in_beat_i.letter_code),
    .re_i    (in_fire),
    .raddr_i (letter_pos_q[BUF_AW-1:0]),
    .rdata_o (prev_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_pos_q <= '0;
      prev_len_q   <= '0;
      have_prev_q  <= 1'b0;
      overflow_q   <= 1'b0;
    end else if (in_fire) begin
      if (in_beat_i.word_end) begin
        letter_pos_q <= '0;
        prev_len_q   <= in_beat_i.list_end ? '0 : new_pos;
        have_prev_q  <= !in_beat_i.list_end;
        overflow_q   <= 1'b0;
      end else begin
        letter_pos_q <= new_pos;
        overflow_q   <= s1_d.overflow;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // stage 1: rank compare and verdict
  always_comb begin
    rank_new  = rank_of(rank_tbl, s1_q.code);
    rank_prev = rank_of(rank_tbl, prev_code);
    pair_new  = pair_q;
    if (s1_q.cmp_en && (pair_q == ST_EQUAL) && (rank_new != rank_prev)) begin
      pair_new = (rank_new < rank_prev) ? ST_BEFORE : ST_AFTER;
    end
    in_order = !s1_q.had_prev ||
               !((pair_new == ST_BEFORE) || ((pair_new == ST_EQUAL) && s1_q.shorter));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q   <= ST_EQUAL;
      sorted_q <= 1'b1;
    end else if (s1_fire) begin
      if (s1_q.word_end) begin
        pair_q   <= ST_EQUAL;
        sorted_q <= s1_q.list_end ? 1'b1 : (sorted_q && in_order);
      end else begin
        pair_q <= pair_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_q.word_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.word_end) begin
      out_q.pair_in_order <= in_order;
      out_q.list_sorted   <= sorted_q && in_order;
      out_q.list_done     <= s1_q.list_end;
      out_q.word_too_long <= s1_q.overflow;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // checks
  `CHK_ALWAYS(a_pos_bound, clk_i, rst_ni, letter_pos_q <= POS_W'(MAX_WORD_LEN))
  `CHK_ALWAYS(a_verdict_sticky, clk_i, rst_ni,
              !out_valid_o || out_beat_o.pair_in_order || !out_beat_o.list_sorted)
  `CHK_NEXT(a_list_restart, clk_i, rst_ni,
            in_fire && in_beat_i.word_end && in_beat_i.list_end,
            !have_prev_q && (prev_len_q == '0))
  `CHK_NEXT(a_stall_only_on_result, clk_i, rst_ni,
            in_stall_o, s1_valid_q && s1_q.word_end)

endmodule

>>> tb/sv/tb_custom_order_word_sort_checker.sv
// Self-checking testbench for custom_order_word_sort_checker: a directed table, then
// random word lists under several letter orders, each verdict beat checked in order.
// Depends on cwsc_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb_custom_order_word_sort_checker;
  import cwsc_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_BEATS  = 90;

  typedef enum int {
    ORD_IDENTITY,
    ORD_REVERSE,
    ORD_SHUFFLE,
    ORD_DUPS,
    ORD_ZERO,
    ORD_ONES
  } order_e;

  typedef struct {
    order_e     order;
    logic [4:0] code;
    bit         wend;
    bit         lend;
    int         reps;
    bit         typed;
    out_beat_t  want;
  } step_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [59:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  in_beat_t   in_beat_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_beat_t  out_beat_o;

  custom_order_word_sort_checker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  // predictor copy of the rank registers and word state
  logic [59:0] tbl_low  = '0;
  logic [59:0] tbl_mid  = '0;
  logic [9:0]  tbl_high = '0;
  logic [4:0]  prev_word [64];
  logic [5:0]  prev_len      = '0;
  logic [5:0]  cur_pos       = '0;
  pair_e       cmp_state     = ST_EQUAL;
  bit          have_prev     = 1'b0;
  bit          sorted_so_far = 1'b1;
  bit          overflow      = 1'b0;

  out_beat_t   verdict_q [$];
  step_row_t   dir_rows [$];
  int          bad_verdicts = 0;
  int          quiet_cycles = 0;
  int          beats_sent   = 0;
  bit          hold_req     = 1'b0;
  bit          calm         = 1'b0;
  order_e      cur_order    = ORD_ZERO;

  // generator side: last word of the list being built
  logic [4:0]  gen_word [64];
  int          gen_len = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [4:0] rank_lookup(input logic [4:0] code);
    int idx;
    idx = int'(code);
    if (idx < 12) return tbl_low[idx*5 +: 5];
    if (idx < 24) return tbl_mid[(idx-12)*5 +: 5];
    if (idx < 26) return tbl_high[(idx-24)*5 +: 5];
    return 5'd31;
  endfunction

  task automatic judge_letter(input in_beat_t b, output bit has, output out_beat_t v);
    logic [4:0] rn;
    logic [4:0] rp;
    bit in_order;
    bit sorted;
    v = '0;
    has = b.word_end;
    if (cur_pos < 6'(MAX_WORD_LEN)) begin
      if (have_prev && cur_pos < prev_len && cmp_state == ST_EQUAL) begin
        rn = rank_lookup(b.letter_code);
        rp = rank_lookup(prev_word[cur_pos]);
        if (rn < rp) cmp_state = ST_BEFORE;
        else if (rn > rp) cmp_state = ST_AFTER;
      end
      prev_word[cur_pos] = b.letter_code;
      cur_pos = cur_pos + 6'd1;
    end else begin
      overflow = 1'b1;
    end
    if (b.word_end) begin
      in_order = 1'b1;
      if (have_prev) begin
        if (cmp_state == ST_BEFORE) in_order = 1'b0;
        else if (cmp_state == ST_EQUAL && cur_pos < prev_len) in_order = 1'b0;
      end
      sorted = sorted_so_far && in_order;
      v.pair_in_order = in_order;
      v.list_sorted   = sorted;
      v.list_done     = b.list_end;
      v.word_too_long = overflow;
      prev_len      = cur_pos;
      have_prev     = 1'b1;
      cur_pos       = '0;
      cmp_state     = ST_EQUAL;
      overflow      = 1'b0;
      sorted_so_far = sorted;
      if (b.list_end) begin
        have_prev     = 1'b0;
        prev_len      = '0;
        sorted_so_far = 1'b1;
      end
    end
  endtask

  function automatic in_beat_t mk_beat(input logic [4:0] code, input bit we, input bit le);
    in_beat_t b;
    b.letter_code = code;
    b.word_end    = we;
    b.list_end    = le;
    return b;
  endfunction

  function automatic step_row_t mk_row(input order_e ord, input int code, input bit we,
                                       input bit le, input int reps, input bit typed,
                                       input logic [3:0] want);
    step_row_t r;
    r.order = ord;
    r.code  = 5'(code);
    r.wend  = we;
    r.lend  = le;
    r.reps  = reps;
    r.typed = typed;
    r.want  = out_beat_t'(want);
    return r;
  endfunction

  function automatic logic [4:0] pick_code();
    if ($urandom_range(0, 15) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, 25));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    bit has;
    out_beat_t v;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      in_beat_i  <= in_beat_t'(7'($urandom_range(0, 127)));
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    judge_letter(b, has, v);
    if (has) verdict_q.push_back(typed ? want : v);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_order(input order_e kind);
    int r [26];
    int j;
    int t;
    logic [59:0] lo;
    logic [59:0] mid;
    logic [9:0]  hi;
    logic [63:0] junk;
    for (int i = 0; i < 26; i++) begin
      case (kind)
        ORD_REVERSE: r[i] = 25 - i;
        ORD_DUPS:    r[i] = int'($urandom_range(0, 31));
        ORD_ZERO:    r[i] = 0;
        ORD_ONES:    r[i] = 31;
        default:     r[i] = i;
      endcase
    end
    if (kind == ORD_SHUFFLE) begin
      for (int i = 25; i > 0; i--) begin
        j = int'($urandom_range(0, i));
        t = r[i];
        r[i] = r[j];
        r[j] = t;
      end
    end
    lo = '0;
    mid = '0;
    for (int i = 0; i < 12; i++) begin
      lo[i*5 +: 5]  = 5'(r[i]);
      mid[i*5 +: 5] = 5'(r[12+i]);
    end
    hi = {5'(r[25]), 5'(r[24])};
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_RANK_LOW;
    cfg_wdata_i <= lo;
    tbl_low = lo;
    @(negedge clk_i);
    cfg_idx_i   <= REG_RANK_MID;
    cfg_wdata_i <= mid;
    tbl_mid = mid;
    @(negedge clk_i);
    // bits above the high table are junk the block must drop
    junk = {$urandom, $urandom};
    cfg_idx_i   <= REG_RANK_HIGH;
    cfg_wdata_i <= {junk[49:0], hi};
    tbl_high = hi;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_order = kind;
  endtask

  // well-formed list; each word shares a prefix with the one before and mostly ranks higher
  task automatic send_list();
    int nwords;
    int len;
    int lim;
    int share;
    int tries;
    bit le;
    logic [4:0] word [64];
    logic [4:0] c;
    nwords = int'($urandom_range(1, 6));
    gen_len = 0;
    for (int w = 0; w < nwords; w++) begin
      len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(30, 40))
                                         : int'($urandom_range(1, 6));
      lim = (gen_len < len) ? gen_len : len;
      share = int'($urandom_range(0, lim));
      for (int i = 0; i < len; i++) begin
        if (i < share) begin
          c = gen_word[i];
        end else begin
          c = pick_code();
          if (i == share && i < gen_len && $urandom_range(0, 3) != 0) begin
            tries = 0;
            while (rank_lookup(c) < rank_lookup(gen_word[i]) && tries < 4) begin
              c = pick_code();
              tries++;
            end
          end
        end
        word[i] = c;
      end
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) le = (w == nwords - 1);
        else le = ($urandom_range(0, 3) == 0);
        send_beat(mk_beat(word[i], i == len - 1, le), 1'b0, '0);
        gen_word[i] = word[i];
      end
      gen_len = len;
    end
    gen_len = 0;
  endtask

  task automatic send_noise();
    int n;
    in_beat_t b;
    n = int'($urandom_range(3, 15));
    for (int i = 0; i < n; i++) begin
      b.letter_code = 5'($urandom_range(0, 31));
      b.word_end    = ($urandom_range(0, 2) == 0);
      b.list_end    = 1'($urandom_range(0, 1));
      if (i == n - 1) begin
        b.word_end = 1'b1;
        b.list_end = 1'b1;
      end
      send_beat(b, 1'b0, '0);
    end
    gen_len = 0;
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          bad_verdicts++;
          if (bad_verdicts <= 10)
            $display("unexpected verdict beat %b at %0t", out_beat_o, $realtime);
        end else begin
          want = verdict_q.pop_front();
          if (out_beat_o.pair_in_order !== want.pair_in_order ||
              out_beat_o.list_sorted   !== want.list_sorted   ||
              out_beat_o.list_done     !== want.list_done     ||
              out_beat_o.word_too_long !== want.word_too_long) begin
            bad_verdicts++;
            if (bad_verdicts <= 10)
              $display("verdict mismatch at %0t: expected %b, got %b",
                       $realtime, want, out_beat_o);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    order_e plan [6];
    int phase_start;
    plan = '{ORD_SHUFFLE, ORD_REVERSE, ORD_DUPS, ORD_ONES, ORD_ZERO, ORD_SHUFFLE};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_beat_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_RANK_LOW;
    cfg_wdata_i = '0;

    // reset ranks are all zero, so every letter from a to z ties
    dir_rows.push_back(mk_row(ORD_ZERO, 0, 1, 0, 1, 1, 4'b1100));      // first word
    dir_rows.push_back(mk_row(ORD_ZERO, 25, 1, 0, 1, 1, 4'b1100));     // tie on rank
    dir_rows.push_back(mk_row(ORD_ZERO, 31, 1, 0, 1, 1, 4'b1100));     // code past z ranks 31
    dir_rows.push_back(mk_row(ORD_ZERO, 0, 0, 0, 1, 0, 4'b0000));
    dir_rows.push_back(mk_row(ORD_ZERO, 1, 1, 0, 1, 1, 4'b0000));      // before its predecessor
    dir_rows.push_back(mk_row(ORD_ZERO, 0, 1, 1, 1, 1, 4'b0010));      // shorter, list closes
    dir_rows.push_back(mk_row(ORD_ZERO, 0, 0, 1, 1, 0, 4'b0000));      // list end ignored here
    dir_rows.push_back(mk_row(ORD_ZERO, 0, 1, 0, 1, 1, 4'b1100));
    dir_rows.push_back(mk_row(ORD_ZERO, 0, 1, 1, 1, 1, 4'b0010));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 25, 1, 0, 34, 1, 4'b1101)); // overlong word
    dir_rows.push_back(mk_row(ORD_IDENTITY, 0, 1, 0, 1, 1, 4'b0000));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 0, 1, 1, 1, 1, 4'b1010));  // equal words
    dir_rows.push_back(mk_row(ORD_IDENTITY, 24, 1, 0, 1, 1, 4'b1100));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 26, 1, 0, 1, 1, 4'b1100));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 31, 1, 1, 1, 1, 4'b1110));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 12, 0, 0, 1, 0, 4'b0000));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 13, 1, 0, 1, 0, 4'b0000));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 12, 0, 0, 1, 0, 4'b0000));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 14, 0, 0, 1, 0, 4'b0000));
    dir_rows.push_back(mk_row(ORD_IDENTITY, 13, 1, 1, 1, 0, 4'b0000));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].order != cur_order) set_order(dir_rows[k].order);
      for (int n = 0; n < dir_rows[k].reps; n++) begin
        if (n == dir_rows[k].reps - 1)
          send_beat(mk_beat(dir_rows[k].code, dir_rows[k].wend, dir_rows[k].lend),
                    dir_rows[k].typed, dir_rows[k].want);
        else
          send_beat(mk_beat(dir_rows[k].code, 1'b0, 1'b0), 1'b0, '0);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_order(plan[ph]);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) calm = 1'b1;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_list();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    bad_verdicts += verdict_q.size();
    if (bad_verdicts == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
